// ===== sv/cim_pkg.sv =====
package cim_pkg;

  localparam int PRESSURE_BITS = 16;
  localparam int OFFSET_W = 14;
  localparam int STEP_W   = 10;
  localparam int SAMPLE_W = PRESSURE_BITS;
  localparam int TARGET_W = PRESSURE_BITS + 1;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 14;

  // Event codes carried in the func field
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_POWER = 3'd1;
  localparam logic [2:0] FUNC_LONG  = 3'd2;
  localparam logic [2:0] FUNC_START = 3'd3;
  localparam logic [2:0] FUNC_UP    = 3'd4;
  localparam logic [2:0] FUNC_DOWN  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_STEP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_MAX  = 1'd1;

  localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd26;
  localparam logic [OFFSET_W-1:0] MAX_RESET    = 14'd5000;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 14'd700;

  // Reported inflation state codes
  localparam logic [1:0] INFL_DEFLATED  = 2'd0;
  localparam logic [1:0] INFL_INFLATING = 2'd1;
  localparam logic [1:0] INFL_INFLATED  = 2'd2;
  localparam logic [1:0] INFL_PAUSED    = 2'd3;

  typedef enum logic [3:0] {
    ST_DEFLATED  = 4'b0001,
    ST_INFLATING = 4'b0010,
    ST_INFLATED  = 4'b0100,
    ST_PAUSED    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0]          func;
    logic [SAMPLE_W-1:0] cuff_sample;
    logic                cuff_valid;
    logic [SAMPLE_W-1:0] arterial_sample;
    logic                arterial_valid;
  } cim_in_t;

  typedef struct packed {
    logic                power_on;
    logic [1:0]          inflation_state;
    logic                pump_on;
    logic                valve_on;
    logic                display_on;
    logic [TARGET_W-1:0] goal_pressure;
    logic [OFFSET_W-1:0] offset_value;
    logic                target_reached;
  } cim_out_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      ST_DEFLATED:  c = INFL_DEFLATED;
      ST_INFLATING: c = INFL_INFLATING;
      ST_INFLATED:  c = INFL_INFLATED;
      ST_PAUSED:    c = INFL_PAUSED;
      default:      c = INFL_DEFLATED;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/cuff_inflation_mode_control.sv =====
// A request accepted in one cycle shows its result at out_data in the next.
// Throughput: one request per cycle; the output register lets a new request in while the
// previous result is still being taken, so in_stall rises only when that result is stalled.
// Reset (rst_n low, synchronous): power, lcd, pump and valve off, mode deflated, offset 7.0
// kPa, stored samples zero, offset step 0.26 kPa, offset limit 50.0 kPa, no result pending.
module cuff_inflation_mode_control (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cim_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [cim_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cim_pkg::cim_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cim_pkg::cim_out_t                    out_data
);

  localparam int PW = cim_pkg::PRESSURE_BITS;
  localparam int TW = PW + 1;
  // Sum width: wide enough for a pressure plus the largest offset
  localparam int SW = ((PW > cim_pkg::OFFSET_W) ? PW : cim_pkg::OFFSET_W) + 1;
  localparam logic [TW-1:0] TARGET_MAX = {TW{1'b1}};

  // Configuration registers
  logic [cim_pkg::STEP_W-1:0]   step_r;
  logic [cim_pkg::OFFSET_W-1:0] max_r;

  // Control state
  cim_pkg::mode_t mode_r, mode_nxt;
  logic power_r, power_nxt;
  logic pump_r, pump_nxt;
  logic valve_r, valve_nxt;
  logic lcd_r, lcd_nxt;
  logic [cim_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [PW-1:0] cuff_r, cuff_nxt;
  logic [PW-1:0] art_r, art_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  cim_pkg::cim_out_t out_data_r, out_data_nxt;

  logic accept;
  logic reached;

  logic [cim_pkg::OFFSET_W:0]   off_up;
  logic [cim_pkg::OFFSET_W-1:0] off_up_sat;
  logic [cim_pkg::OFFSET_W-1:0] off_dn_sat;
  logic [SW-1:0]                tgt_sum;
  logic [TW-1:0]                tgt;

  // Hold the input while a finished result is stalled at the output
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cim_pkg::STEP_RESET;
      max_r  <= cim_pkg::MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        cim_pkg::CFG_OFFSET_STEP: step_r <= cfg_wdata[cim_pkg::STEP_W-1:0];
        cim_pkg::CFG_OFFSET_MAX:  max_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset up and down, saturating at the configured limit and at zero
  assign off_up     = {1'b0, offset_r} + (cim_pkg::OFFSET_W + 1)'(step_r);
  assign off_up_sat = (off_up > {1'b0, max_r}) ? max_r : off_up[cim_pkg::OFFSET_W-1:0];
  assign off_dn_sat = (offset_r < cim_pkg::OFFSET_W'(step_r)) ? '0 :
                      offset_r - cim_pkg::OFFSET_W'(step_r);

  // Target from the state after this request; the offset is unchanged on a tick,
  // so the same sum serves the reach check
  assign tgt_sum = SW'(art_nxt) + SW'(offset_nxt);
  assign tgt     = (tgt_sum > SW'(TARGET_MAX)) ? TARGET_MAX : tgt_sum[TW-1:0];

  always_comb begin
    mode_nxt   = mode_r;
    power_nxt  = power_r;
    pump_nxt   = pump_r;
    valve_nxt  = valve_r;
    lcd_nxt    = lcd_r;
    offset_nxt = offset_r;
    cuff_nxt   = cuff_r;
    art_nxt    = art_r;
    reached    = 1'b0;
    case (in_data.func)
      cim_pkg::FUNC_TICK: begin
        // Take the low pressure bits of each fresh sample
        if (in_data.cuff_valid) cuff_nxt = PW'(in_data.cuff_sample);
        if (in_data.arterial_valid) art_nxt = PW'(in_data.arterial_sample);
        if (mode_r == cim_pkg::ST_INFLATING && TW'(cuff_nxt) >= tgt) begin
          mode_nxt = cim_pkg::ST_INFLATED;
          pump_nxt = 1'b0;
          reached  = 1'b1;
        end
      end
      cim_pkg::FUNC_POWER: begin
        if (!power_r) begin
          lcd_nxt   = 1'b1;
          power_nxt = 1'b1;
        end else begin
          // Emergency stop: drop pump and valve, vent to deflated
          pump_nxt  = 1'b0;
          valve_nxt = 1'b0;
          mode_nxt  = cim_pkg::ST_DEFLATED;
        end
      end
      cim_pkg::FUNC_LONG: begin
        if (power_r) begin
          lcd_nxt   = 1'b0;
          valve_nxt = 1'b0;
          pump_nxt  = 1'b0;
          power_nxt = 1'b0;
        end
      end
      cim_pkg::FUNC_START: begin
        if (mode_r == cim_pkg::ST_DEFLATED) begin
          mode_nxt  = cim_pkg::ST_INFLATING;
          valve_nxt = 1'b1;
          pump_nxt  = 1'b1;
        end else begin
          mode_nxt  = cim_pkg::ST_PAUSED;
          pump_nxt  = 1'b0;
          valve_nxt = 1'b1;
        end
      end
      cim_pkg::FUNC_UP:   offset_nxt = off_up_sat;
      cim_pkg::FUNC_DOWN: offset_nxt = off_dn_sat;
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt.power_on        = power_nxt;
    out_data_nxt.inflation_state = cim_pkg::mode_code(mode_nxt);
    out_data_nxt.pump_on         = pump_nxt;
    out_data_nxt.valve_on        = valve_nxt;
    out_data_nxt.display_on      = lcd_nxt;
    out_data_nxt.goal_pressure   = cim_pkg::TARGET_W'(tgt);
    out_data_nxt.offset_value    = offset_nxt;
    out_data_nxt.target_reached  = reached;
  end

  // Load on accept, clear once taken, hold while stalled
  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cim_pkg::ST_DEFLATED;
      power_r     <= 1'b0;
      pump_r      <= 1'b0;
      valve_r     <= 1'b0;
      lcd_r       <= 1'b0;
      offset_r    <= cim_pkg::OFFSET_RESET;
      cuff_r      <= '0;
      art_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        mode_r   <= mode_nxt;
        power_r  <= power_nxt;
        pump_r   <= pump_nxt;
        valve_r  <= valve_nxt;
        lcd_r    <= lcd_nxt;
        offset_r <= offset_nxt;
        cuff_r   <= cuff_nxt;
        art_r    <= art_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pump never runs against an open valve
  a_pump_needs_valve: assert property (@(posedge clk) disable iff (!rst_n)
    pump_r |-> valve_r) else $error("pump on with valve open");

  // The pump only runs while inflating
  a_pump_only_inflating: assert property (@(posedge clk) disable iff (!rst_n)
    pump_r |-> (mode_r == cim_pkg::ST_INFLATING)) else $error("pump on outside inflating");

  // Display follows power
  a_lcd_tracks_power: assert property (@(posedge clk) disable iff (!rst_n)
    lcd_r == power_r) else $error("lcd and power disagree");

  // A reach report comes with the cuff inflated and the pump stopped
  a_reached_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.target_reached) |->
      (out_data_r.inflation_state == cim_pkg::INFL_INFLATED && !out_data_r.pump_on))
    else $error("target reached reported in wrong state");

  // A request taken on a tick while inflating leaves inflating or reports no reach
  a_reach_leaves_inflating: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && reached) |=> (mode_r == cim_pkg::ST_INFLATED))
    else $error("reach did not move mode to inflated");

endmodule

// ===== verif/cuff_mode_checker.sv =====
module cuff_mode_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cim_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  cim_pkg::cim_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  cim_pkg::cim_out_t              out_data,
  output int                             fail_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = cim_pkg::TARGET_W;
  localparam int OW = cim_pkg::OFFSET_W;
  localparam int KW = cim_pkg::STEP_W;

  logic [KW-1:0]                 step_cfg;
  logic [OW-1:0]                 max_cfg;
  logic                          pwr_on;
  logic                          lcd_on;
  logic                          pump_run;
  logic                          valve_hold;
  logic [1:0]                    infl_mode;
  logic [OW-1:0]                 offset_now;
  logic [cim_pkg::SAMPLE_W-1:0]  cuff_held;
  logic [cim_pkg::SAMPLE_W-1:0]  art_held;

  cim_pkg::cim_out_t status_q[$];

  // Arterial plus offset, clamped to the target width.
  function automatic logic [TW-1:0] cuff_target();
    logic [TW:0] sum;
    sum = {2'b00, art_held} + {{(TW + 1 - OW){1'b0}}, offset_now};
    return (sum > {1'b0, {TW{1'b1}}}) ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

  // Advance the controller state by one event and build the status it reports.
  function automatic cim_pkg::cim_out_t apply_event(cim_pkg::cim_in_t ev);
    cim_pkg::cim_out_t r;
    logic              hit;
    logic [OW:0]       grown;
    hit = 1'b0;
    case (ev.func)
      cim_pkg::FUNC_TICK: begin
        if (ev.cuff_valid) cuff_held = ev.cuff_sample;
        if (ev.arterial_valid) art_held = ev.arterial_sample;
        if (infl_mode == cim_pkg::INFL_INFLATING && {1'b0, cuff_held} >= cuff_target()) begin
          infl_mode = cim_pkg::INFL_INFLATED;
          pump_run  = 1'b0;
          hit       = 1'b1;
        end
      end
      cim_pkg::FUNC_POWER: begin
        if (!pwr_on) begin
          lcd_on = 1'b1;
          pwr_on = 1'b1;
        end else begin
          pump_run   = 1'b0;
          valve_hold = 1'b0;
          infl_mode  = cim_pkg::INFL_DEFLATED;
        end
      end
      cim_pkg::FUNC_LONG: begin
        if (pwr_on) begin
          lcd_on     = 1'b0;
          valve_hold = 1'b0;
          pump_run   = 1'b0;
          pwr_on     = 1'b0;
        end
      end
      cim_pkg::FUNC_START: begin
        if (infl_mode == cim_pkg::INFL_DEFLATED) begin
          infl_mode  = cim_pkg::INFL_INFLATING;
          valve_hold = 1'b1;
          pump_run   = 1'b1;
        end else begin
          infl_mode  = cim_pkg::INFL_PAUSED;
          pump_run   = 1'b0;
          valve_hold = 1'b1;
        end
      end
      cim_pkg::FUNC_UP: begin
        grown      = {1'b0, offset_now} + {{(OW + 1 - KW){1'b0}}, step_cfg};
        offset_now = (grown > {1'b0, max_cfg}) ? max_cfg : grown[OW-1:0];
      end
      cim_pkg::FUNC_DOWN: begin
        if (offset_now < {{(OW - KW){1'b0}}, step_cfg}) offset_now = '0;
        else offset_now = offset_now - {{(OW - KW){1'b0}}, step_cfg};
      end
      default: ;
    endcase
    r.power_on        = pwr_on;
    r.inflation_state = infl_mode;
    r.pump_on         = pump_run;
    r.valve_on        = valve_hold;
    r.display_on      = lcd_on;
    r.goal_pressure   = cuff_target();
    r.offset_value    = offset_now;
    r.target_reached  = hit;
    return r;
  endfunction

  function automatic bit field_differs(string name, logic [TW-1:0] want,
                                       logic [TW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cim_pkg::cim_out_t want;
    bit                bad;
    if (rst_n !== 1'b1) begin
      step_cfg   = cim_pkg::STEP_RESET;
      max_cfg    = cim_pkg::MAX_RESET;
      pwr_on     = 1'b0;
      lcd_on     = 1'b0;
      pump_run   = 1'b0;
      valve_hold = 1'b0;
      infl_mode  = cim_pkg::INFL_DEFLATED;
      offset_now = cim_pkg::OFFSET_RESET;
      cuff_held  = '0;
      art_held   = '0;
      fail_count = 0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == cim_pkg::CFG_OFFSET_STEP) step_cfg = cfg_wdata[KW-1:0];
        else if (cfg_addr == cim_pkg::CFG_OFFSET_MAX) max_cfg = cfg_wdata[OW-1:0];
      end
      // Results come from the output register, so retire before predicting.
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t ns: status with no request outstanding, expected none actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          bad  = 1'b0;
          bad |= field_differs("power_on", TW'(want.power_on), TW'(out_data.power_on));
          bad |= field_differs("inflation_state", TW'(want.inflation_state),
                               TW'(out_data.inflation_state));
          bad |= field_differs("pump_on", TW'(want.pump_on), TW'(out_data.pump_on));
          bad |= field_differs("valve_on", TW'(want.valve_on), TW'(out_data.valve_on));
          bad |= field_differs("display_on", TW'(want.display_on),
                               TW'(out_data.display_on));
          bad |= field_differs("goal_pressure", want.goal_pressure,
                               out_data.goal_pressure);
          bad |= field_differs("offset_value", TW'(want.offset_value),
                               TW'(out_data.offset_value));
          bad |= field_differs("target_reached", TW'(want.target_reached),
                               TW'(out_data.target_reached));
          if (bad) fail_count++;
        end
      end
      if (in_valid && !in_stall) status_q.push_back(apply_event(in_data));
    end
    pending_count = status_q.size();
  end

endmodule

// ===== verif/tb_cuff_inflation_mode_control.sv =====
module tb_cuff_inflation_mode_control;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = cim_pkg::SAMPLE_W;

  // Event codes the block decodes as no-ops
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  localparam int PHASE_ITEMS = 234;
  localparam int CYCLE_LIMIT = 200000;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cim_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [cim_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  cim_pkg::cim_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  cim_pkg::cim_out_t              out_data;

  int fail_count;
  int pending_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int item_count     = 0;

  cuff_inflation_mode_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  cuff_mode_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Start high so the first falling edge lands after the time-zero drive.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Stall the result side at random; a zero rate gives a free-running receiver.
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Hard stop in case a handshake hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_cuff_inflation_mode_control: FAIL");
      $finish;
    end
  end

  // Build a click event; sample fields carry noise the block must ignore.
  function automatic cim_pkg::cim_in_t make_click(logic [2:0] f);
    cim_pkg::cim_in_t ev;
    ev.func            = f;
    ev.cuff_sample     = SW'($urandom);
    ev.cuff_valid      = 1'($urandom);
    ev.arterial_sample = SW'($urandom);
    ev.arterial_valid  = 1'($urandom);
    return ev;
  endfunction

  function automatic cim_pkg::cim_in_t make_tick(logic [SW-1:0] cuff, logic cv,
                                                 logic [SW-1:0] art, logic av);
    cim_pkg::cim_in_t ev;
    ev.func            = cim_pkg::FUNC_TICK;
    ev.cuff_sample     = cuff;
    ev.cuff_valid      = cv;
    ev.arterial_sample = art;
    ev.arterial_valid  = av;
    return ev;
  endfunction

  // Present one request and hold it until the block takes it. Called and
  // returns at a falling edge; valid stays high into the next request unless
  // an idle gap drops it.
  task automatic offer_request(cim_pkg::cim_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // Spare codes do nothing, so leave them out of the tally.
    if (req.func <= cim_pkg::FUNC_DOWN) item_count++;
  endtask

  // Drop valid and hold off until every outstanding status has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both registers back to back; only call with the block idle.
  task automatic program_settings(int step, int max_lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= cim_pkg::CFG_OFFSET_STEP;
    cfg_wdata <= cim_pkg::CFG_DATA_W'(step);
    @(negedge clk);
    cfg_addr  <= cim_pkg::CFG_OFFSET_MAX;
    cfg_wdata <= cim_pkg::CFG_DATA_W'(max_lim);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One full inflation: force power on and deflated with two power clicks,
  // start, then ramp the cuff past the target with clicks mixed in.
  task automatic run_inflation_cycle();
    logic [SW-1:0] art;
    logic [SW-1:0] cuff;
    logic [SW:0]   bumped;
    logic          cv;
    logic          av;
    logic          done;
    int            ticks;
    int            roll;
    art  = SW'($urandom_range(2000, 50000));
    cuff = art - SW'($urandom_range(0, 2000));
    offer_request(make_click(cim_pkg::FUNC_POWER));
    offer_request(make_click(cim_pkg::FUNC_POWER));
    offer_request(make_click(cim_pkg::FUNC_START));
    offer_request(make_tick(cuff, 1'b1, art, 1'b1));
    ticks = 0;
    done  = 1'b0;
    while (ticks < 60 && !done) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        offer_request(make_click(cim_pkg::FUNC_UP));
      end else if (roll < 12) begin
        offer_request(make_click(cim_pkg::FUNC_DOWN));
      end else if (roll < 15) begin
        // Pause mid-ramp and abandon this cycle.
        offer_request(make_click(cim_pkg::FUNC_START));
        done = 1'b1;
      end else begin
        bumped = {1'b0, cuff} + (SW + 1)'($urandom_range(30, 900));
        cuff   = bumped[SW] ? {SW{1'b1}} : bumped[SW-1:0];
        cv     = ($urandom_range(0, 9) != 0);
        av     = ($urandom_range(0, 9) == 0);
        if (av) art = art + SW'($urandom_range(0, 200)) - SW'(100);
        offer_request(make_tick(cv ? cuff : SW'($urandom), cv,
                                av ? art : SW'($urandom), av));
        if (&cuff || {1'b0, cuff} > {1'b0, art} + 17'd11000) done = 1'b1;
      end
      ticks++;
    end
  endtask

  // Mostly well-formed inflation cycles, the rest fully random events.
  task automatic run_phase(int send_pct, int recv_pct, int step, int max_lim);
    cim_pkg::cim_in_t noise;
    int               quota;
    wait_for_results();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    program_settings(step, max_lim);
    quota = item_count + PHASE_ITEMS;
    while (item_count < quota) begin
      if ($urandom_range(0, 3) != 0) begin
        run_inflation_cycle();
      end else begin
        noise.func            = 3'($urandom_range(0, 7));
        noise.cuff_sample     = SW'($urandom);
        noise.cuff_valid      = 1'($urandom);
        noise.arterial_sample = SW'($urandom);
        noise.arterial_valid  = 1'($urandom);
        offer_request(noise);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= cim_pkg::CFG_OFFSET_STEP;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part runs under the first phase's idling.
    send_idle_pct  = 29;
    recv_stall_pct = 79;

    // Spare codes and a long press while off change nothing.
    offer_request(make_click(FUNC_SPARE_A));
    offer_request(make_click(FUNC_SPARE_B));
    offer_request(make_click(cim_pkg::FUNC_LONG));
    // Start does not look at power; power on then keeps the mode.
    offer_request(make_click(cim_pkg::FUNC_START));
    offer_request(make_click(cim_pkg::FUNC_POWER));
    // Extreme samples: cuff at zero and full scale, arterial at full scale.
    offer_request(make_tick('0, 1'b1, '1, 1'b1));
    offer_request(make_tick('1, 1'b1, '0, 1'b0));
    // Arterial chosen so the held cuff lands exactly on the target.
    offer_request(make_tick('0, 1'b0, SW'(65535 - 700), 1'b1));
    // Neither sample valid: keep both held values.
    offer_request(make_tick('1, 1'b0, '1, 1'b0));
    // Start from inflated, then from paused.
    offer_request(make_click(cim_pkg::FUNC_START));
    offer_request(make_click(cim_pkg::FUNC_START));
    offer_request(make_click(cim_pkg::FUNC_UP));
    offer_request(make_click(cim_pkg::FUNC_DOWN));
    // Power click while on acts as the emergency stop.
    offer_request(make_click(cim_pkg::FUNC_POWER));
    offer_request(make_click(cim_pkg::FUNC_START));
    // Long press while on: power off, mode kept.
    offer_request(make_click(cim_pkg::FUNC_LONG));
    offer_request(make_tick('0, 1'b1, '0, 1'b1));
    offer_request(make_tick(SW'(cim_pkg::OFFSET_RESET), 1'b1, '0, 1'b0));

    // Offset clamps at the upper limit and stops at zero.
    wait_for_results();
    program_settings(1000, 1000);
    offer_request(make_click(cim_pkg::FUNC_UP));
    offer_request(make_click(cim_pkg::FUNC_UP));
    offer_request(make_click(cim_pkg::FUNC_DOWN));
    offer_request(make_click(cim_pkg::FUNC_DOWN));

    // Zero step and zero limit.
    wait_for_results();
    program_settings(0, 0);
    offer_request(make_click(cim_pkg::FUNC_UP));
    offer_request(make_click(cim_pkg::FUNC_DOWN));

    run_phase(29, 79, $urandom_range(1, 60), 10000);
    run_phase(79, 29, 1000, $urandom_range(0, 10000));
    run_phase(0, 0, $urandom_range(0, 1000), $urandom_range(0, 10000));

    // Drain the tail, then idle the output register before the verdict.
    wait_for_results();
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_cuff_inflation_mode_control: PASS");
    end else begin
      $display("tb_cuff_inflation_mode_control: FAIL");
    end
    $finish;
  end

endmodule
